// File: hdl/fia_pkg.sv
// ----------------------------------------------------------------------------
// fia_pkg
// Types, codes and float helpers shared by the interval unit.
// ----------------------------------------------------------------------------
package fia_pkg;

  typedef enum logic [2:0] {
    FN_NEG   = 3'd0,
    FN_ADD   = 3'd1,
    FN_MUL   = 3'd2,
    FN_ISECT = 3'd3,
    FN_HULL  = 3'd4,
    FN_CLAMP = 3'd5
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] a_lower;
    logic [31:0] a_upper;
    logic [31:0] b_lower;
    logic [31:0] b_upper;
  } in_item_t;

  typedef struct packed {
    logic [31:0] r_lower;
    logic [31:0] r_upper;
    logic        r_empty;
    logic        a_holds_b;
    logic        a_meets_b;
    logic        a_is_finite;
    logic        a_has_nan;
  } out_item_t;

  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic [31:0] NEG_INF = 32'hFF80_0000;
  localparam logic [31:0] FMAX    = 32'h7F7F_FFFF;
  localparam logic [31:0] QNAN    = 32'h7FC0_0000;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // ordered x < y
  function automatic logic f_lt(input logic [31:0] x, input logic [31:0] y);
    logic r;
    if (is_nan(x) || is_nan(y)) r = 1'b0;
    else if (is_zero(x) && is_zero(y)) r = 1'b0;
    else if (x[31] != y[31]) r = x[31];
    else if (x[31]) r = x[30:0] > y[30:0];
    else r = x[30:0] < y[30:0];
    return r;
  endfunction

  function automatic logic [31:0] f_min(input logic [31:0] x, input logic [31:0] y);
    return f_lt(y, x) ? y : x;
  endfunction

  function automatic logic [31:0] f_max(input logic [31:0] x, input logic [31:0] y);
    return f_lt(x, y) ? y : x;
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] x);
    return is_nan(x) ? QNAN : x;
  endfunction

  function automatic logic [31:0] clamp_end(input logic [31:0] x);
    logic [31:0] r;
    if (x[30:23] != 8'hFF) r = x;
    else if (!is_nan(x) && x[31]) r = {1'b1, FMAX[30:0]};
    else r = FMAX;
    return r;
  endfunction

  // Front half of an add: align operands. Returns packed fields.
  typedef struct packed {
    logic        special;   // result given directly
    logic [31:0] sres;
    logic        sgn;       // sign of larger
    logic        sub;
    logic [7:0]  exp;       // exponent of larger (biased, min 1)
    logic [26:0] big;       // 1.23 + guard,round,sticky
    logic [26:0] sml;       // shifted, sticky in lsb
  } add_al_t;

  function automatic add_al_t add_align(input logic [31:0] x, input logic [31:0] y);
    add_al_t r;
    logic [31:0] p, q;
    logic [7:0]  ep, eq, d;
    logic [26:0] mp, mq, sh;
    logic        st;
    r = '0;
    if (is_nan(x) || is_nan(y)) begin
      r.special = 1'b1; r.sres = QNAN;
    end else if (x[30:23] == 8'hFF && y[30:23] == 8'hFF) begin
      r.special = 1'b1; r.sres = (x[31] == y[31]) ? x : QNAN;
    end else if (x[30:23] == 8'hFF) begin
      r.special = 1'b1; r.sres = x;
    end else if (y[30:23] == 8'hFF) begin
      r.special = 1'b1; r.sres = y;
    end else if (is_zero(x) && is_zero(y)) begin
      r.special = 1'b1; r.sres = {x[31] & y[31], 31'd0};
    end else begin
      if (x[30:0] >= y[30:0]) begin p = x; q = y; end
      else begin p = y; q = x; end
      ep = (p[30:23] == 8'd0) ? 8'd1 : p[30:23];
      eq = (q[30:23] == 8'd0) ? 8'd1 : q[30:23];
      mp = {(p[30:23] != 8'd0), p[22:0], 3'b000};
      mq = {(q[30:23] != 8'd0), q[22:0], 3'b000};
      d  = ep - eq;
      if (d > 8'd26) begin
        sh = 27'd0; st = (mq != 27'd0);
      end else begin
        sh = mq >> d;
        st = ((sh << d) != mq);
      end
      r.sgn = p[31];
      r.sub = p[31] ^ q[31];
      r.exp = ep;
      r.big = mp;
      r.sml = {sh[26:1], sh[0] | st};
    end
    return r;
  endfunction

  // Round a normalised value: m has leading one at bit 26 (or zero/subnormal).
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [9:0] e,
                                             input logic [26:0] m);
    logic [26:0] mm;
    logic signed [9:0] ee;
    logic [9:0] sft;
    logic [24:0] mr;
    logic [31:0] r;
    logic st;
    mm = m; ee = e;
    if (ee < 10'sd1) begin
      sft = 10'(10'sd1 - ee);
      if (sft > 10'd27) begin st = (mm != 27'd0); mm = 27'd0; end
      else begin st = ((mm >> sft) << sft) != mm; mm = mm >> sft; end
      mm[0] = mm[0] | st;
      ee = 10'sd0;
    end
    mr = {1'b0, mm[26:3]};
    if (mm[2] && (mm[1] || mm[0] || mm[3])) mr = mr + 25'd1;
    if (ee == 10'sd0) begin
      // subnormal; carry into bit 23 makes smallest normal
      r = {sgn, 8'(mr[23]), mr[22:0]};
    end else begin
      if (mr[24]) begin ee = ee + 10'sd1; mr = mr >> 1; end
      if (ee >= 10'sd255) r = {sgn, 8'hFF, 23'd0};
      else r = {sgn, ee[7:0], mr[22:0]};
    end
    return r;
  endfunction

endpackage

// File: hdl/float_interval_alu_top.sv
// ----------------------------------------------------------------------------
// float_interval_alu_top
// Single-precision interval unit: negate, add, multiply, intersect, hull and
// clamp on intervals A and B, with containment, overlap and class flags.
// ----------------------------------------------------------------------------
// Four register stages: operand alignment and mantissa multiply, normalise,
// round, then hull of products, ordering and flags into the output register.
// One item enters per cycle while in_ready is high; a stalled output holds
// every full stage in place, while earlier items still advance into empty
// stages.
module float_interval_alu_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fia_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fia_pkg::out_item_t  out_data
);

  typedef struct packed {
    logic        sgn;
    logic        zero;
    logic        special;
    logic [31:0] sres;
    logic signed [9:0] exp;
    logic [47:0] prod;
  } mul_t;

  // stage valids and advance
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;
  assign adv4 = !v4 || out_ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ready = adv1;
  assign out_valid = v4;

  // ---------------- stage 1: align adds, multiply mantissas
  fia_pkg::in_item_t s1_in;
  fia_pkg::add_al_t s1_add [2];
  mul_t s1_mul [4];

  function automatic mul_t mul_front(input logic [31:0] x, input logic [31:0] y);
    mul_t r;
    logic [23:0] mx, my;
    r = '0;
    r.sgn = x[31] ^ y[31];
    if (fia_pkg::is_zero(x) || fia_pkg::is_zero(y)) r.zero = 1'b1;
    else if (fia_pkg::is_nan(x) || fia_pkg::is_nan(y)) begin
      r.special = 1'b1; r.sres = fia_pkg::QNAN;
    end else if (x[30:23] == 8'hFF || y[30:23] == 8'hFF) begin
      r.special = 1'b1; r.sres = {r.sgn, 8'hFF, 23'd0};
    end else begin
      mx = {(x[30:23] != 8'd0), x[22:0]};
      my = {(y[30:23] != 8'd0), y[22:0]};
      r.exp = 10'(signed'({2'b00, (x[30:23] == 8'd0) ? 8'd1 : x[30:23]}))
            + 10'(signed'({2'b00, (y[30:23] == 8'd0) ? 8'd1 : y[30:23]})) - 10'sd127;
      r.prod = mx * my;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv1) v1 <= in_valid;
    if (adv1) begin
      s1_in <= in_data;
      s1_add[0] <= fia_pkg::add_align(in_data.b_lower, in_data.a_lower);
      s1_add[1] <= fia_pkg::add_align(in_data.b_upper, in_data.a_upper);
      s1_mul[0] <= mul_front(in_data.b_lower, in_data.a_lower);
      s1_mul[1] <= mul_front(in_data.b_lower, in_data.a_upper);
      s1_mul[2] <= mul_front(in_data.b_upper, in_data.a_lower);
      s1_mul[3] <= mul_front(in_data.b_upper, in_data.a_upper);
    end
  end

  // ---------------- stage 2: add/sub and normalise; product normalise
  typedef struct packed {
    logic        special;
    logic [31:0] sres;
    logic        sgn;
    logic signed [9:0] exp;
    logic [26:0] man;
  } norm_t;

  function automatic norm_t add_norm(input fia_pkg::add_al_t a);
    norm_t r;
    logic [27:0] s;
    logic [4:0] lz;
    logic found;
    r = '0;
    r.special = a.special; r.sres = a.sres; r.sgn = a.sgn;
    if (!a.special) begin
      s = a.sub ? ({1'b0, a.big} - {1'b0, a.sml}) : ({1'b0, a.big} + {1'b0, a.sml});
      if (s == 28'd0) begin
        r.special = 1'b1; r.sres = 32'd0;
      end else if (s[27]) begin
        r.exp = 10'(signed'({2'b00, a.exp})) + 10'sd1;
        r.man = {s[27:2], s[1] | s[0]};
      end else begin
        lz = 5'd0; found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
          if (!found && s[i]) begin found = 1'b1; lz = 5'(26 - i); end
        end
        // let the exponent fall below one; round_pack shifts back to subnormal
        r.exp = 10'(signed'({2'b00, a.exp})) - 10'(signed'({5'd0, lz}));
        r.man = s[26:0] << lz;
      end
    end
    return r;
  endfunction

  function automatic norm_t mul_norm(input mul_t m);
    norm_t r;
    logic [5:0] lz;
    logic found;
    logic [47:0] p;
    r = '0;
    r.sgn = m.sgn;
    if (m.zero) begin r.special = 1'b1; r.sres = 32'd0; end
    else if (m.special) begin r.special = 1'b1; r.sres = m.sres; end
    else begin
      lz = 6'd0; found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
        if (!found && m.prod[i]) begin found = 1'b1; lz = 6'(47 - i); end
      end
      p = m.prod << lz;
      r.exp = m.exp + 10'sd1 - 10'(signed'({4'd0, lz}));
      r.man = {p[47:22], p[21:0] != 22'd0};
    end
    return r;
  endfunction

  fia_pkg::in_item_t s2_in;
  norm_t s2_add [2];
  norm_t s2_mul [4];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv2) v2 <= v1;
    if (adv2) begin
      s2_in <= s1_in;
      for (int i = 0; i < 2; i++) s2_add[i] <= add_norm(s1_add[i]);
      for (int i = 0; i < 4; i++) s2_mul[i] <= mul_norm(s1_mul[i]);
    end
  end

  // ---------------- stage 3: round, select raw ends
  function automatic logic [31:0] fin(input norm_t n);
    return n.special ? n.sres : fia_pkg::round_pack(n.sgn, n.exp, n.man);
  endfunction

  fia_pkg::in_item_t s3_in;
  logic [31:0] s3_e0, s3_e1, s3_p [4];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv3) v3 <= v2;
    if (adv3) begin
      s3_in <= s2_in;
      s3_e0 <= fin(s2_add[0]);
      s3_e1 <= fin(s2_add[1]);
      for (int i = 0; i < 4; i++) s3_p[i] <= fin(s2_mul[i]);
    end
  end

  // ---------------- stage 4: order, select, flags
  logic [31:0] rl, ru, ml, mu;
  fia_pkg::func_t fn;

  always_comb begin
    ml = fia_pkg::POS_INF;
    mu = fia_pkg::NEG_INF;
    for (int i = 0; i < 4; i++) begin
      ml = fia_pkg::f_min(ml, s3_p[i]);
      mu = fia_pkg::f_max(mu, s3_p[i]);
    end
    fn = fia_pkg::func_t'(s3_in.func);
    rl = s3_in.a_lower;
    ru = s3_in.a_upper;
    unique case (fn)
      fia_pkg::FN_NEG: begin
        rl = fia_pkg::f_min({~s3_in.a_upper[31], s3_in.a_upper[30:0]},
                            {~s3_in.a_lower[31], s3_in.a_lower[30:0]});
        ru = fia_pkg::f_max({~s3_in.a_upper[31], s3_in.a_upper[30:0]},
                            {~s3_in.a_lower[31], s3_in.a_lower[30:0]});
      end
      fia_pkg::FN_ADD: begin
        rl = fia_pkg::f_min(s3_e0, s3_e1);
        ru = fia_pkg::f_max(s3_e0, s3_e1);
      end
      fia_pkg::FN_MUL: begin rl = ml; ru = mu; end
      fia_pkg::FN_ISECT: begin
        rl = fia_pkg::f_max(s3_in.a_lower, s3_in.b_lower);
        ru = fia_pkg::f_min(s3_in.a_upper, s3_in.b_upper);
      end
      fia_pkg::FN_HULL: begin
        rl = fia_pkg::f_min(s3_in.a_lower, s3_in.b_lower);
        ru = fia_pkg::f_max(s3_in.a_upper, s3_in.b_upper);
      end
      fia_pkg::FN_CLAMP: begin
        rl = fia_pkg::clamp_end(s3_in.a_lower);
        ru = fia_pkg::clamp_end(s3_in.a_upper);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv4) v4 <= v3;
    if (adv4) begin
      out_data.r_lower <= fia_pkg::canon(rl);
      out_data.r_upper <= fia_pkg::canon(ru);
      out_data.r_empty <= fia_pkg::f_lt(ru, rl);
      out_data.a_holds_b <=
        (!fia_pkg::f_lt(s3_in.b_lower, s3_in.a_lower) && !fia_pkg::is_nan(s3_in.b_lower)
         && !fia_pkg::is_nan(s3_in.a_lower) || s3_in.a_lower == fia_pkg::NEG_INF) &&
        (!fia_pkg::f_lt(s3_in.a_upper, s3_in.b_upper) && !fia_pkg::is_nan(s3_in.b_upper)
         && !fia_pkg::is_nan(s3_in.a_upper) || s3_in.a_upper == fia_pkg::POS_INF);
      out_data.a_meets_b <=
        !fia_pkg::f_lt(s3_in.a_upper, s3_in.b_lower) && !fia_pkg::is_nan(s3_in.a_upper)
        && !fia_pkg::is_nan(s3_in.b_lower) &&
        !fia_pkg::f_lt(s3_in.b_upper, s3_in.a_lower) && !fia_pkg::is_nan(s3_in.b_upper)
        && !fia_pkg::is_nan(s3_in.a_lower);
      out_data.a_is_finite <= (s3_in.a_lower[30:23] != 8'hFF) &&
                              (s3_in.a_upper[30:23] != 8'hFF);
      out_data.a_has_nan <= fia_pkg::is_nan(s3_in.a_lower) || fia_pkg::is_nan(s3_in.a_upper);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed under stall");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted item lost at entry");
  a_nan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !fia_pkg::is_nan(out_data.r_lower) || out_data.r_lower == fia_pkg::QNAN)
    else $error("non-canonical NaN on output");

endmodule
